@@ src/knap_pkg.sv @@
`default_nettype none

package knap_pkg;

    localparam int VALUE_W   = 23;
    localparam int VAL_IN_W  = 16;
    localparam int WEIGHT_W  = 8;
    localparam int CAP_W     = 8;
    localparam int MAX_CAP_DEF = 255;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    typedef struct packed {
        logic [VAL_IN_W-1:0] item_value;
        logic [WEIGHT_W-1:0] item_weight;
        logic                last_item;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0] best_value;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_done;

endpackage

`default_nettype wire

@@ src/knap_if.sv @@
`default_nettype none

interface knap_item_if import knap_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface knap_result_if import knap_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface knap_cfg_if import knap_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/knapsack_01_optimizer.sv @@
// Channel   Dir  Payload                                   Accepted when
// i_cfg     in   data: capacity                            valid && ready
// i_item    in   item_value, item_weight, last_item        valid && ready
// o_result  out  best_value                                valid && ready
//
// An item is accepted in S_IDLE; S_SWEEP then reads the table entries from
// MAX_CAPACITY down to 1 via the dual-read table memory, and S_DRAIN writes back
// the last entry. A last item adds S_FINISH to load the output register.
// Reset needs no clearing pass: the first item of a set reads the table as zero
// and rewrites entries 1 to MAX_CAPACITY. i_cfg is always ready; i_item is ready
// only between sweeps and, at the end of a set, stalls on a full output register.
`default_nettype none

module knapsack_01_optimizer import knap_pkg::*; #(
    parameter int MAX_CAPACITY = MAX_CAP_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    knap_cfg_if.sink      i_cfg,
    knap_item_if.sink     i_item,
    knap_result_if.source o_result
);

    localparam int DEPTH = MAX_CAPACITY + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [CAP_W-1:0]   r_capacity;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;

    logic               out_free;
    t_done              done;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic [VALUE_W-1:0] rd_data_a;
    logic [VALUE_W-1:0] rd_data_b;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;

    assign i_cfg.ready              = 1'b1;
    assign out_free                 = !r_out_valid || o_result.ready;
    assign o_result.valid           = r_out_valid;
    assign o_result.data.best_value = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.data;
            end
            if (done.valid) begin
                r_out_valid <= 1'b1;
                r_out_value <= done.value;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    knap_sweep #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .AW           (AW)
    ) u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_item.valid),
        .o_ready     (i_item.ready),
        .i_item      (i_item.data),
        .i_capacity  (r_capacity),
        .i_out_free  (out_free),
        .o_done      (done),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_data_a (rd_data_a),
        .i_rd_data_b (rd_data_b),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    knap_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    a_no_wr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr != '0))
        else $error("table write to capacity zero");

    a_idle_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> !wr_en)
        else $error("item accepted while write-back pending");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !done.valid)
        else $error("result overwrites pending transaction");

    a_done_from_idle_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done.valid |=> i_item.ready)
        else $error("sweep not idle after result");

endmodule

`default_nettype wire

@@ src/knap_ram.sv @@
`default_nettype none

module knap_ram import knap_pkg::*; #(
    parameter int DEPTH = MAX_CAP_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [VALUE_W-1:0] i_wr_data,
    input  logic [AW-1:0]      i_rd_addr_a,
    input  logic [AW-1:0]      i_rd_addr_b,
    output logic [VALUE_W-1:0] o_rd_data_a,
    output logic [VALUE_W-1:0] o_rd_data_b
);

    logic [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

@@ src/knap_sweep.sv @@
`default_nettype none

module knap_sweep import knap_pkg::*; #(
    parameter int MAX_CAPACITY = MAX_CAP_DEF,
    parameter int AW           = $clog2(MAX_CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    input  logic [CAP_W-1:0]   i_capacity,
    input  logic               i_out_free,
    output t_done              o_done,
    output logic [AW-1:0]      o_rd_addr_a,
    output logic [AW-1:0]      o_rd_addr_b,
    input  logic [VALUE_W-1:0] i_rd_data_a,
    input  logic [VALUE_W-1:0] i_rd_data_b,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [VALUE_W-1:0] o_wr_data
);

    localparam int CW = (AW > CAP_W) ? AW : CAP_W;
    localparam int SW = VALUE_W + 1;
    localparam logic [AW-1:0] TOP_C = AW'(MAX_CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_c;
    logic [VAL_IN_W-1:0]  r_v;
    logic [WEIGHT_W-1:0]  r_w;
    logic                 r_last;
    logic [AW-1:0]        r_cap;
    logic                 r_fresh;
    logic                 r_pend;
    logic [AW-1:0]        r_wr_c;
    logic                 r_fit;
    logic                 r_base_zero;
    logic [VALUE_W-1:0]   r_result;

    logic                 fit;
    logic [AW-1:0]        base_addr;
    logic [AW-1:0]        cap_eff;
    logic [VALUE_W-1:0]   old_val;
    logic [VALUE_W-1:0]   base_val;
    logic [SW-1:0]        sum;
    logic [VALUE_W-1:0]   take;
    logic [VALUE_W-1:0]   new_val;

    always_comb begin
        fit       = CW'(r_w) <= CW'(r_c);
        base_addr = fit ? (r_c - AW'(r_w)) : '0;
        cap_eff   = (CW'(i_capacity) > CW'(MAX_CAPACITY)) ? TOP_C : AW'(i_capacity);
        old_val   = r_fresh ? '0 : i_rd_data_a;
        base_val  = (r_fresh || r_base_zero) ? '0 : i_rd_data_b;
        sum       = {1'b0, base_val} + SW'(r_v);
        take      = (sum > {1'b0, VALUE_MAX}) ? VALUE_MAX : sum[VALUE_W-1:0];
        new_val   = (r_fit && (take > old_val)) ? take : old_val;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_done.valid = (r_state == S_FINISH) && i_out_free;
    assign o_done.value = r_result;
    assign o_rd_addr_a  = r_c;
    assign o_rd_addr_b  = base_addr;
    assign o_wr_en      = r_pend;
    assign o_wr_addr    = r_wr_c;
    assign o_wr_data    = new_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fresh <= 1'b1;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            if (r_pend && (r_wr_c == r_cap)) begin
                r_result <= new_val;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_v      <= i_item.item_value;
                        r_w      <= i_item.item_weight;
                        r_last   <= i_item.last_item;
                        r_cap    <= cap_eff;
                        r_result <= '0;
                        r_c      <= TOP_C;
                        r_state  <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_pend      <= 1'b1;
                    r_wr_c      <= r_c;
                    r_fit       <= fit;
                    r_base_zero <= (base_addr == '0);
                    r_c         <= r_c - 1'b1;
                    if (r_c == AW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_fresh <= r_last;
                    r_state <= r_last ? S_FINISH : S_IDLE;
                end
                S_FINISH: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_knapsack_01_optimizer.sv @@
`timescale 1ns / 100ps

module tb_knapsack_01_optimizer;
    import knap_pkg::*;

    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 4000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 125;
    localparam int PRESSURE_PHASE = 3;

    class knapsack_ledger;
        logic [VALUE_W-1:0] best_by_cap [0:MAX_CAP_DEF];
        logic [CAP_W-1:0]   capacity;
        logic [VALUE_W-1:0] expected_best [$];
        int                 errors;

        function new();
            foreach (best_by_cap[i]) best_by_cap[i] = '0;
            capacity = '0;
            errors   = 0;
        endfunction

        function void note_error(string msg);
            if (errors < 10) begin
                $display("mismatch at %0t: %s", $time, msg);
            end
            errors++;
        endfunction

        function void fold_item(t_item it);
            logic [VALUE_W:0] take;
            int c;
            for (c = MAX_CAP_DEF; c >= 1; c--) begin
                if (it.item_weight <= c) begin
                    take = {1'b0, best_by_cap[c - it.item_weight]} + it.item_value;
                    if (take > VALUE_MAX) begin
                        take = VALUE_MAX;
                    end
                    if (take[VALUE_W-1:0] > best_by_cap[c]) begin
                        best_by_cap[c] = take[VALUE_W-1:0];
                    end
                end
            end
            best_by_cap[0] = '0;
            if (it.last_item) begin
                expected_best.push_back(best_by_cap[capacity]);
                foreach (best_by_cap[i]) best_by_cap[i] = '0;
            end
        endfunction

        function void check_best(t_result got);
            logic [VALUE_W-1:0] want;
            if (expected_best.size() == 0) begin
                note_error($sformatf("unexpected result best_value=%0d", got.best_value));
                return;
            end
            want = expected_best.pop_front();
            if (got.best_value !== want) begin
                note_error($sformatf("best_value expected %0d actual %0d",
                                     want, got.best_value));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   tx_idle_en;
    bit   rx_idle_en;
    bit   hold_request;

    knap_item_if   item_if ();
    knap_cfg_if    cfg_if ();
    knap_result_if result_if ();

    knapsack_ledger ledger = new();

    knapsack_01_optimizer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_item   (item_if),
        .o_result (result_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_item(input t_item it);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
        ledger.fold_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input int v, input int w, input bit last);
        t_item it;
        it.item_value  = v[VAL_IN_W-1:0];
        it.item_weight = w[WEIGHT_W-1:0];
        it.last_item   = last;
        send_item(it);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= c;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        ledger.capacity = c;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // drop valid, wait for every pending result, then let the sweep finish
    task automatic settle();
        item_if.valid <= 1'b0;
        while (ledger.expected_best.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'hFFFF;
            1:       return 0;
            2:       return $urandom_range(0, 15);
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic int pick_weight(input int cap);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            2, 3:    return $urandom_range(0, cap);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    initial begin : result_sink
        result_if.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                result_if.ready <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            ledger.check_best(result_if.data);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_if.valid && item_if.ready) || (cfg_if.valid && cfg_if.ready)
                    || (result_if.valid && result_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_knapsack_01_optimizer failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;
        int cap;
        int max_len;
        int set_left;
        bit set_long;

        item_if.valid = 1'b0;
        item_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        i_rst_n       = 1'b0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_request  = 1'b0;
        set_left      = 0;
        set_long      = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_capacity(8'd255);
        send_fields(16'hFFFF, 0, 1'b0);
        send_fields(0, 255, 1'b0);
        send_fields(16'h8000, 128, 1'b0);
        send_fields(1, 1, 1'b1);
        send_fields(1234, 0, 1'b1);
        send_fields(500, 255, 1'b1);
        settle();

        write_capacity(8'd0);
        send_fields(16'hFFFF, 0, 1'b1);
        send_fields(100, 1, 1'b0);
        settle();
        // change the limit with a set still open
        write_capacity(8'd1);
        send_fields(200, 1, 1'b1);
        settle();

        write_capacity(8'd7);
        send_fields(16'hFFFF, 255, 1'b0);
        send_fields(10, 3, 1'b0);
        send_fields(20, 4, 1'b0);
        send_fields(15, 5, 1'b1);
        send_fields(16'h5555, 8'hAA, 1'b0);
        send_fields(16'hAAAA, 8'h55, 1'b1);
        settle();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 0 || phase == NUM_PHASES - 1) begin
                cap = 255;
            end else if (phase == 1) begin
                cap = 0;
            end else if ($urandom_range(0, 1) == 0) begin
                cap = $urandom_range(0, 31);
            end else begin
                cap = $urandom_range(0, 255);
            end
            write_capacity(cap[CAP_W-1:0]);

            max_len = (phase == PRESSURE_PHASE) ? 2 : $urandom_range(3, 12);
            if (phase == PRESSURE_PHASE) begin
                hold_request = 1'b1;
            end
            if (phase == NUM_PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end

            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (set_left == 0) begin
                    set_long = (phase != PRESSURE_PHASE) && ($urandom_range(0, 39) == 0);
                    set_left = set_long ? $urandom_range(130, 160)
                                        : $urandom_range(1, max_len);
                end
                if (set_long) begin
                    send_fields($urandom_range(0, 3) == 0 ? pick_value() : 16'hFFFF,
                                $urandom_range(0, 2), set_left == 1);
                end else begin
                    send_fields(pick_value(), pick_weight(cap), set_left == 1);
                end
                set_left--;
            end
            settle();
        end

        if (ledger.errors == 0 && ledger.expected_best.size() == 0) begin
            $display("tb_knapsack_01_optimizer passed");
        end else begin
            $display("tb_knapsack_01_optimizer failed");
        end
        $finish;
    end

endmodule
